// ----- rtl/ghi_pkg.sv -----
package ghi_pkg;

   // Request codes carried by req_type
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_CAL    = 2'd1,
      OP_SET    = 2'd2,
      OP_SUB    = 2'd3
   } op_type;

   // Configuration register indexes and port widths
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_NEGATE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_NEGATE  = 3'd4;

   localparam logic [23:0] GYRO_GAIN_RST     = 24'd17855;
   localparam logic [23:0] ACCEL_GAIN_RST    = 24'd156906;
   localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd16777;

   // Depth of the command queue between front and back
   localparam int unsigned CMD_QUEUE_DEPTH = 2;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] raw_accel;
      logic signed [15:0] raw_gyro;
      logic signed [47:0] angle_value;
   } cmd_type;

   typedef struct packed {
      logic [23:0] gyro_gain;
      logic [23:0] accel_gain;
      logic [23:0] sample_period;
      logic        gyro_negate;
      logic        accel_negate;
   } cfg_type;

endpackage

// ----- rtl/ghi_front.sv -----
module ghi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic signed [15:0]  req_raw_accel,
   input  logic signed [15:0]  req_raw_gyro,
   input  logic signed [47:0]  req_angle_value,
   output logic                cmd_valid,
   output ghi_pkg::cmd_type    cmd,
   input  logic                cmd_pop
);

   localparam int unsigned PTR_W = $clog2(ghi_pkg::CMD_QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(ghi_pkg::CMD_QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ghi_pkg::CMD_QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ghi_pkg::CMD_QUEUE_DEPTH - 1);

   ghi_pkg::cmd_type  q_mem_ff [ghi_pkg::CMD_QUEUE_DEPTH];
   ghi_pkg::cmd_type  cmd_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;

   assign req_stall = (count_ff == FULL_CNT);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_mem_ff[rd_ptr_ff];

   // Classify the request into a queued command
   always_comb begin
      cmd_in.op          = ghi_pkg::op_type'(req_type);
      cmd_in.raw_accel   = req_raw_accel;
      cmd_in.raw_gyro    = req_raw_gyro;
      cmd_in.angle_value = req_angle_value;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- rtl/ghi_back.sv -----
module ghi_back #(
   parameter int unsigned REF_COUNT = 100
) (
   input  logic                clock,
   input  logic                reset,
   input  ghi_pkg::cfg_type    cfg,
   input  logic                cmd_valid,
   input  ghi_pkg::cmd_type    cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_rate_out,
   output logic signed [47:0]  rsp_heading_out,
   output logic signed [20:0]  rsp_accel_out,
   output logic                rsp_cal_busy
);

   // Reciprocal for the average: floor(n * DIV_MUL / 2^31) == n / REF_COUNT
   // for every magnitude below 2^24 and REF_COUNT below 128
   localparam logic [63:0] DIV_NUM   = 64'd1 << 31;
   localparam logic [63:0] DIV_MUL64 =
      (DIV_NUM + 64'(REF_COUNT) - 64'd1) / 64'(REF_COUNT);
   localparam logic [31:0] DIV_MUL   = DIV_MUL64[31:0];
   localparam logic [7:0]  REF_LIMIT = 8'(REF_COUNT);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_PROD  = 9'b000000010,
      ST_SCALE = 9'b000000100,
      ST_INTEG = 9'b000001000,
      ST_HEAD  = 9'b000010000,
      ST_DIVM  = 9'b000100000,
      ST_DIVS  = 9'b001000000,
      ST_CMD   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   ghi_pkg::cmd_type    cmd_ff, cmd_in;

   logic signed [41:0]  p_ff, p_in;
   logic signed [41:0]  q_ff, q_in;
   logic signed [31:0]  rate_ff, rate_in;
   logic signed [20:0]  acc_ff, acc_in;
   logic signed [55:0]  inc_ff, inc_in;
   logic [55:0]         gq_ff, gq_in;
   logic [55:0]         aq_ff, aq_in;

   logic signed [15:0]  gyro_bias_ff, gyro_bias_in;
   logic signed [15:0]  accel_bias_ff, accel_bias_in;
   logic signed [23:0]  gyro_sum_ff, gyro_sum_in;
   logic signed [23:0]  accel_sum_ff, accel_sum_in;
   logic [6:0]          cal_count_ff, cal_count_in;
   logic                cal_active_ff, cal_active_in;
   logic [47:0]         heading_ff, heading_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_rate_ff, rsp_rate_in;
   logic signed [47:0]  rsp_heading_ff, rsp_heading_in;
   logic signed [20:0]  rsp_accel_ff, rsp_accel_in;
   logic                rsp_cal_busy_ff, rsp_cal_busy_in;

   logic signed [16:0]  dg, da;
   logic signed [41:0]  p_neg, q_neg;
   logic signed [33:0]  rate_wide;
   logic signed [25:0]  acc_wide;
   logic [7:0]          count_next;
   logic [23:0]         g_mag, a_mag;
   logic [16:0]         g_quot, a_quot;
   logic                rsp_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rate_out    = rsp_rate_ff;
   assign rsp_heading_out = rsp_heading_ff;
   assign rsp_accel_out   = rsp_accel_ff;
   assign rsp_cal_busy    = rsp_cal_busy_ff;

   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Datapath pieces
   always_comb begin
      dg = $signed({cmd_ff.raw_gyro[15], cmd_ff.raw_gyro})
         - $signed({gyro_bias_ff[15], gyro_bias_ff});
      da = $signed({cmd_ff.raw_accel[15], cmd_ff.raw_accel})
         - $signed({accel_bias_ff[15], accel_bias_ff});
      p_neg = cfg.gyro_negate ? -p_ff : p_ff;
      q_neg = cfg.accel_negate ? -q_ff : q_ff;
      rate_wide = p_neg[41:8];
      acc_wide  = q_neg[41:16];
      count_next = {1'b0, cal_count_ff} + 8'd1;
      g_mag  = gyro_sum_ff[23] ? (24'd0 - gyro_sum_ff) : gyro_sum_ff;
      a_mag  = accel_sum_ff[23] ? (24'd0 - accel_sum_ff) : accel_sum_ff;
      g_quot = gq_ff[47:31];
      a_quot = aq_ff[47:31];
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      p_in            = p_ff;
      q_in            = q_ff;
      rate_in         = rate_ff;
      acc_in          = acc_ff;
      inc_in          = inc_ff;
      gq_in           = gq_ff;
      aq_in           = aq_ff;
      gyro_bias_in    = gyro_bias_ff;
      accel_bias_in   = accel_bias_ff;
      gyro_sum_in     = gyro_sum_ff;
      accel_sum_in    = accel_sum_ff;
      cal_count_in    = cal_count_ff;
      cal_active_in   = cal_active_ff;
      heading_in      = heading_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_rate_in     = rsp_rate_ff;
      rsp_heading_in  = rsp_heading_ff;
      rsp_accel_in    = rsp_accel_ff;
      rsp_cal_busy_in = rsp_cal_busy_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               state_in = (cmd.op == ghi_pkg::OP_SAMPLE) ? ST_PROD : ST_CMD;
            end
         end
         ST_PROD: begin
            p_in     = dg * $signed({1'b0, cfg.gyro_gain});
            q_in     = da * $signed({1'b0, cfg.accel_gain});
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // Saturate the floored rate and acceleration
            if (rate_wide[33:31] == 3'b000 || rate_wide[33:31] == 3'b111) begin
               rate_in = rate_wide[31:0];
            end else if (rate_wide[33]) begin
               rate_in = 32'sh8000_0000;
            end else begin
               rate_in = 32'sh7FFF_FFFF;
            end
            if (acc_wide[25:20] == 6'b000000 || acc_wide[25:20] == 6'b111111) begin
               acc_in = acc_wide[20:0];
            end else if (acc_wide[25]) begin
               acc_in = 21'sh10_0000;
            end else begin
               acc_in = 21'sh0F_FFFF;
            end
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            inc_in   = rate_ff * $signed({1'b0, cfg.sample_period});
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            heading_in = heading_ff + inc_ff[55:8];
            state_in   = ST_DONE;
            if (cal_active_ff) begin
               gyro_sum_in  = gyro_sum_ff
                            + {{8{cmd_ff.raw_gyro[15]}}, cmd_ff.raw_gyro};
               accel_sum_in = accel_sum_ff
                            + {{8{cmd_ff.raw_accel[15]}}, cmd_ff.raw_accel};
               cal_count_in = count_next[6:0];
               if (count_next >= REF_LIMIT) begin
                  state_in = ST_DIVM;
               end
            end
         end
         ST_DIVM: begin
            gq_in    = {32'd0, g_mag} * {24'd0, DIV_MUL};
            aq_in    = {32'd0, a_mag} * {24'd0, DIV_MUL};
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            // Truncate toward zero: divide the magnitude, restore the sign
            gyro_bias_in  = gyro_sum_ff[23] ? 16'(17'd0 - g_quot) : g_quot[15:0];
            accel_bias_in = accel_sum_ff[23] ? 16'(17'd0 - a_quot) : a_quot[15:0];
            cal_active_in = 1'b0;
            state_in      = ST_DONE;
         end
         ST_CMD: begin
            rate_in = '0;
            acc_in  = '0;
            unique case (cmd_ff.op)
               ghi_pkg::OP_CAL: begin
                  gyro_sum_in   = '0;
                  accel_sum_in  = '0;
                  cal_count_in  = '0;
                  cal_active_in = 1'b1;
               end
               ghi_pkg::OP_SET: heading_in = cmd_ff.angle_value;
               ghi_pkg::OP_SUB: heading_in = heading_ff - cmd_ff.angle_value;
               ghi_pkg::OP_SAMPLE: heading_in = heading_ff;
            endcase
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_rate_in     = rate_ff;
               rsp_heading_in  = heading_ff;
               rsp_accel_in    = acc_ff;
               rsp_cal_busy_in = cal_active_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         gyro_bias_ff  <= '0;
         accel_bias_ff <= '0;
         gyro_sum_ff   <= '0;
         accel_sum_ff  <= '0;
         cal_count_ff  <= '0;
         cal_active_ff <= 1'b0;
         heading_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         gyro_bias_ff  <= gyro_bias_in;
         accel_bias_ff <= accel_bias_in;
         gyro_sum_ff   <= gyro_sum_in;
         accel_sum_ff  <= accel_sum_in;
         cal_count_ff  <= cal_count_in;
         cal_active_ff <= cal_active_in;
         heading_ff    <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      p_ff            <= p_in;
      q_ff            <= q_in;
      rate_ff         <= rate_in;
      acc_ff          <= acc_in;
      inc_ff          <= inc_in;
      gq_ff           <= gq_in;
      aq_ff           <= aq_in;
      rsp_rate_ff     <= rsp_rate_in;
      rsp_heading_ff  <= rsp_heading_in;
      rsp_accel_ff    <= rsp_accel_in;
      rsp_cal_busy_ff <= rsp_cal_busy_in;
   end

endmodule

// ----- rtl/gyro_heading_integrator_core.sv -----
// Sequence: a sample request passes the back-end states PROD, SCALE, INTEG, HEAD and DONE,
// with DIVM and DIVS after HEAD when it closes a calibration run; calibration, set and
// subtract requests pass CMD and DONE. The back-end sequencer steps through its chained
// multiplies one request at a time; a 2-entry queue decouples the front.
// Reset (synchronous): registers return to their defaults, biases, sums and heading clear.
module gyro_heading_integrator_core #(
   parameter int unsigned REF_COUNT = 100
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic signed [15:0]               req_raw_accel,
   input  logic signed [15:0]               req_raw_gyro,
   input  logic signed [47:0]               req_angle_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_rate_out,
   output logic signed [47:0]               rsp_heading_out,
   output logic signed [20:0]               rsp_accel_out,
   output logic                             rsp_cal_busy,
   input  logic                             csr_wen,
   input  logic [ghi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ghi_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ghi_pkg::cfg_type  cfg_ff, cfg_in;
   ghi_pkg::cmd_type  cmd;
   logic              cmd_valid;
   logic              cmd_pop;

   // Configuration writes; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            ghi_pkg::CSR_GYRO_GAIN:     cfg_in.gyro_gain     = csr_wdata;
            ghi_pkg::CSR_ACCEL_GAIN:    cfg_in.accel_gain    = csr_wdata;
            ghi_pkg::CSR_SAMPLE_PERIOD: cfg_in.sample_period = csr_wdata;
            ghi_pkg::CSR_GYRO_NEGATE:   cfg_in.gyro_negate   = csr_wdata[0];
            ghi_pkg::CSR_ACCEL_NEGATE:  cfg_in.accel_negate  = csr_wdata[0];
            default:                    cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gyro_gain     <= ghi_pkg::GYRO_GAIN_RST;
         cfg_ff.accel_gain    <= ghi_pkg::ACCEL_GAIN_RST;
         cfg_ff.sample_period <= ghi_pkg::SAMPLE_PERIOD_RST;
         cfg_ff.gyro_negate   <= 1'b0;
         cfg_ff.accel_negate  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ghi_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_raw_accel   (req_raw_accel),
      .req_raw_gyro    (req_raw_gyro),
      .req_angle_value (req_angle_value),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   ghi_back #(
      .REF_COUNT (REF_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rate_out    (rsp_rate_out),
      .rsp_heading_out (rsp_heading_out),
      .rsp_accel_out   (rsp_accel_out),
      .rsp_cal_busy    (rsp_cal_busy)
   );

endmodule
